// ----- hdl/dts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg: shared types of the token scanner
// result record passed from the scan core through the result queue
// ----------------------------------------------------------------------------
package dts_pkg;

	localparam int unsigned LINE_W = 20;

	// token kinds as seen on the kind port
	typedef enum logic [2:0] {
		KIND_END    = 3'd0,
		KIND_WORD   = 3'd1,
		KIND_NUM    = 3'd2,
		KIND_AT     = 3'd3,
		KIND_LBRACE = 3'd4,
		KIND_RBRACE = 3'd5,
		KIND_SEMI   = 3'd6,
		KIND_DOLLAR = 3'd7
	} kind_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [LINE_W-1:0] line_no;
		logic [7:0]       word_char;
		logic             word_first;
		logic             negative;
		logic [31:0]      int_part;
		logic             int_overflow;
		logic [29:0]      frac_value;
		logic [3:0]       frac_len;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

// ----- hdl/dts_scan_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_scan_core: scanner state and per-byte decode
// one byte in, up to two result records out in the same cycle
// ----------------------------------------------------------------------------
module dts_scan_core #(
	parameter int unsigned WORD_MAX_LEN = 126,
	parameter int unsigned NUM_MAX_LEN  = 62,
	parameter int unsigned FRAC_DIGITS  = 9
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      ch,
	output dts_pkg::res_t        res0,
	output dts_pkg::res_t        res1,
	output logic [1:0]           res_cnt
);

	localparam int unsigned LW = 7;
	localparam int unsigned LNW = dts_pkg::LINE_W;
	localparam logic [LW-1:0] WORD_LIM = LW'(WORD_MAX_LEN);
	localparam logic [LW-1:0] NUM_LIM  = LW'(NUM_MAX_LEN);
	localparam logic [3:0]    FRAC_LIM = 4'(FRAC_DIGITS);
	localparam logic [LNW-1:0] LINE_MAX = {LNW{1'b1}};
	localparam logic [LNW-1:0] LINE_ONE = LNW'(1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_SLASH   = 3'd2,
		MODE_MINUS   = 3'd3,
		MODE_WORD    = 3'd4,
		MODE_NUM     = 3'd5
	} mode_t;

	typedef struct packed {
		logic        negative;
		logic [31:0] int_part;
		logic        ovf;
		logic [1:0]  dots;
		logic [29:0] frac;
		logic [3:0]  frac_len;
	} num_t;

	localparam num_t NUM_CLEAR = '0;

	mode_t          mode_q;
	logic [LW-1:0]  len_q;
	logic [LNW-1:0] line_q;
	num_t           num_q;

	mode_t          n_mode;
	logic [LW-1:0]  n_len;
	logic [LNW-1:0] n_line;
	num_t           n_num;
	logic           put_a;
	logic           put_b;
	logic           do_fresh;
	dts_pkg::res_t  res_a;
	dts_pkg::res_t  res_b;
	logic           is_digit;
	logic           is_wstart;

	function automatic num_t num_take(num_t s, logic [7:0] c);
		num_t        r;
		logic [7:0]  dc;
		logic [3:0]  d;
		logic [35:0] v;
		r  = s;
		dc = c - CH_ZERO;
		d  = dc[3:0];
		v  = 36'({s.int_part, 3'b000}) + 36'({s.int_part, 1'b0}) + 36'(d);
		if (c == CH_DOT) begin
			if (r.dots != 2'd2) r.dots = r.dots + 2'd1;
		end else if (r.dots == 2'd0) begin
			if (r.ovf || (v[35:32] != 4'd0)) begin
				r.int_part = '1;
				r.ovf      = 1'b1;
			end else begin
				r.int_part = v[31:0];
			end
		end else if ((r.dots == 2'd1) && (r.frac_len < FRAC_LIM)) begin
			r.frac     = 30'({r.frac, 3'b000}) + 30'({r.frac, 1'b0}) + 30'(d);
			r.frac_len = r.frac_len + 4'd1;
		end
		return r;
	endfunction

	function automatic dts_pkg::res_t mk_res(logic [2:0] kind, logic [LNW-1:0] line,
			logic [7:0] wc, logic wf, logic is_num, num_t nm);
		dts_pkg::res_t r;
		r              = '0;
		r.kind         = kind;
		r.line_no      = line;
		r.word_char    = wc;
		r.word_first   = wf;
		if (is_num) begin
			r.negative     = nm.negative;
			r.int_part     = nm.int_part;
			r.int_overflow = nm.ovf;
			r.frac_value   = nm.frac;
			r.frac_len     = nm.frac_len;
		end
		return r;
	endfunction

	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_wstart = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ||
		((ch >= CH_UP_A) && (ch <= CH_UP_Z)) || (ch == CH_UNDER);

	always_comb begin
		n_mode   = mode_q;
		n_len    = len_q;
		n_line   = line_q;
		n_num    = num_q;
		put_a    = 1'b0;
		put_b    = 1'b0;
		do_fresh = 1'b0;
		res_a    = '0;
		res_b    = '0;

		// mode-specific handling
		case (mode_q)
			MODE_COMMENT: begin
				if ((ch == CH_NUL) || (ch == CH_LF)) do_fresh = 1'b1;
			end
			MODE_SLASH: begin
				if (ch == CH_SLASH) n_mode = MODE_COMMENT;
				else do_fresh = 1'b1;
			end
			MODE_MINUS: begin
				if (is_digit) begin
					n_num          = NUM_CLEAR;
					n_num.negative = 1'b1;
					n_num          = num_take(n_num, ch);
					n_mode         = MODE_NUM;
					n_len          = LW'(2);
					if (n_len >= NUM_LIM) begin
						put_a  = 1'b1;
						res_a  = mk_res(dts_pkg::KIND_NUM, n_line, 8'h00, 1'b0, 1'b1,
							n_num);
						n_mode = MODE_IDLE;
						n_len  = '0;
					end
				end else begin
					do_fresh = 1'b1;
				end
			end
			MODE_WORD: begin
				if (is_wstart || is_digit) begin
					put_a = 1'b1;
					res_a = mk_res(dts_pkg::KIND_WORD, n_line, ch, 1'b0, 1'b0, n_num);
					n_len = len_q + LW'(1);
					if (n_len >= WORD_LIM) begin
						n_mode = MODE_IDLE;
						n_len  = '0;
					end
				end else begin
					do_fresh = 1'b1;
				end
			end
			MODE_NUM: begin
				if (is_digit || (ch == CH_DOT)) begin
					n_num = num_take(num_q, ch);
					n_len = len_q + LW'(1);
					if (n_len >= NUM_LIM) begin
						put_a  = 1'b1;
						res_a  = mk_res(dts_pkg::KIND_NUM, n_line, 8'h00, 1'b0, 1'b1,
							n_num);
						n_mode = MODE_IDLE;
						n_len  = '0;
					end
				end else begin
					// number ends, then the byte is scanned afresh
					put_a    = 1'b1;
					res_a    = mk_res(dts_pkg::KIND_NUM, n_line, 8'h00, 1'b0, 1'b1, num_q);
					do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		// byte scanned from idle
		if (do_fresh) begin
			n_mode = MODE_IDLE;
			n_len  = '0;
			if (ch == CH_NUL) begin
				put_b  = 1'b1;
				res_b  = mk_res(dts_pkg::KIND_END, n_line, 8'h00, 1'b0, 1'b0, n_num);
				n_line = LINE_ONE;
				n_num  = NUM_CLEAR;
			end else if (ch == CH_LF) begin
				if (n_line != LINE_MAX) n_line = n_line + LINE_ONE;
			end else if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) ||
					(ch == CH_FF) || (ch == CH_CR)) begin
				n_mode = MODE_IDLE;
			end else if (ch == CH_HASH) begin
				n_mode = MODE_COMMENT;
			end else if (ch == CH_SLASH) begin
				n_mode = MODE_SLASH;
			end else if (ch == CH_AT) begin
				put_b = 1'b1;
				res_b = mk_res(dts_pkg::KIND_AT, n_line, 8'h00, 1'b0, 1'b0, n_num);
			end else if (ch == CH_LBRACE) begin
				put_b = 1'b1;
				res_b = mk_res(dts_pkg::KIND_LBRACE, n_line, 8'h00, 1'b0, 1'b0, n_num);
			end else if (ch == CH_RBRACE) begin
				put_b = 1'b1;
				res_b = mk_res(dts_pkg::KIND_RBRACE, n_line, 8'h00, 1'b0, 1'b0, n_num);
			end else if (ch == CH_SEMI) begin
				put_b = 1'b1;
				res_b = mk_res(dts_pkg::KIND_SEMI, n_line, 8'h00, 1'b0, 1'b0, n_num);
			end else if (ch == CH_DOLLAR) begin
				put_b = 1'b1;
				res_b = mk_res(dts_pkg::KIND_DOLLAR, n_line, 8'h00, 1'b0, 1'b0, n_num);
			end else if (is_digit) begin
				n_num  = num_take(NUM_CLEAR, ch);
				n_mode = MODE_NUM;
				n_len  = LW'(1);
				if (n_len >= NUM_LIM) begin
					put_b  = 1'b1;
					res_b  = mk_res(dts_pkg::KIND_NUM, n_line, 8'h00, 1'b0, 1'b1, n_num);
					n_mode = MODE_IDLE;
					n_len  = '0;
				end
			end else if (ch == CH_MINUS) begin
				n_mode = MODE_MINUS;
			end else if (is_wstart) begin
				put_b  = 1'b1;
				res_b  = mk_res(dts_pkg::KIND_WORD, n_line, ch, 1'b1, 1'b0, n_num);
				n_len  = LW'(1);
				n_mode = MODE_WORD;
				if (n_len >= WORD_LIM) begin
					n_mode = MODE_IDLE;
					n_len  = '0;
				end
			end
		end
	end

	// compact the two slots and mark the final record
	always_comb begin
		res_cnt = {1'b0, put_a} + {1'b0, put_b};
		res0    = put_a ? res_a : res_b;
		res1    = res_b;
		res0.last = (res_cnt == 2'd1);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			line_q <= LINE_ONE;
			num_q  <= NUM_CLEAR;
		end else if (fire) begin
			mode_q <= n_mode;
			len_q  <= n_len;
			line_q <= n_line;
			num_q  <= n_num;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dts_result_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_result_fifo: four-entry result queue
// takes up to two records a cycle, and while the output is not stalled hands out one
// ----------------------------------------------------------------------------
module dts_result_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    wr_cnt,
	input  dts_pkg::res_t      wr_res0,
	input  dts_pkg::res_t      wr_res1,
	output logic               room,
	output logic               out_valid,
	input  wire logic          out_stall,
	output dts_pkg::res_t      head
);

	dts_pkg::res_t mem_q [4];
	logic [1:0]    wr_ptr_q;
	logic [1:0]    rd_ptr_q;
	logic [2:0]    count_q;
	logic          pop;

	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	// two free slots needed for the worst case of one byte
	assign room      = (count_q <= 3'd2);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) mem_q[wr_ptr_q] <= wr_res0;
		if (wr_cnt == 2'd2) mem_q[wr_ptr_q + 2'd1] <= wr_res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + wr_cnt;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q  <= count_q + {1'b0, wr_cnt} - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dsl_token_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dsl_token_scanner: streaming tokenizer for a small text language
// one source byte per request in, tokens out one per request
// ----------------------------------------------------------------------------
// usage
//  input channel: ch with in_valid / in_stall, one source byte per request
//  output channel: one token per request with out_valid / out_stall
//  a zero byte flushes a pending number, sends the end token and returns
//  the scanner, line count included, to its reset state
//  a byte is registered in the input stage, decoded from there once the
//  queue has room, and its tokens are written to the queue for output
//  throughput: one byte per cycle while each byte gives at most one token
//  and the output is not stalled; a byte that gives two tokens (number end
//  plus a new token) writes both at once, read out by the single-read queue
//  the queue holds four records; the input stalls while it cannot take
//  the two records one byte may cause, so an output stall backs up to the
//  input and no token is lost
//  reset: asynchronous, clears scanner state and the queue, line count 1
// ----------------------------------------------------------------------------
module dsl_token_scanner #(
	parameter int unsigned WORD_MAX_LEN = 126,
	parameter int unsigned NUM_MAX_LEN  = 62,
	parameter int unsigned FRAC_DIGITS  = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// source byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	// token channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [19:0]      line_no,
	output logic [7:0]       word_char,
	output logic             word_first,
	output logic             negative,
	output logic [31:0]      int_part,
	output logic             int_overflow,
	output logic [29:0]      frac_value,
	output logic [3:0]       frac_len,
	output logic             last
);

	// input register stage
	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          room;
	logic          fire;
	logic          in_take;
	dts_pkg::res_t res0;
	dts_pkg::res_t res1;
	logic [1:0]    res_cnt;
	logic [1:0]    wr_cnt;
	dts_pkg::res_t head;

	// byte in the stage is decoded once the queue has room for two records
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_take  = in_valid && !in_stall;
	assign wr_cnt   = fire ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_take) ch_s1 <= ch;
	end

	dts_scan_core #(
		.WORD_MAX_LEN (WORD_MAX_LEN),
		.NUM_MAX_LEN  (NUM_MAX_LEN),
		.FRAC_DIGITS  (FRAC_DIGITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.ch      (ch_s1),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	dts_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cnt    (wr_cnt),
		.wr_res0   (res0),
		.wr_res1   (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// head of the queue drives the token ports
	assign kind         = head.kind;
	assign line_no      = head.line_no;
	assign word_char    = head.word_char;
	assign word_first   = head.word_first;
	assign negative     = head.negative;
	assign int_part     = head.int_part;
	assign int_overflow = head.int_overflow;
	assign frac_value   = head.frac_value;
	assign frac_len     = head.frac_len;
	assign last         = head.last;

endmodule

`default_nettype wire
